// ===== rtl/battery_soc_sop_estimator_core_defines.svh =====
// assertion macros for the battery soc/sop estimator core
// used by the top level; clk and rst_n must be in scope where expanded
`ifndef BATTERY_SOC_SOP_ESTIMATOR_CORE_DEFINES_SVH
`define BATTERY_SOC_SOP_ESTIMATOR_CORE_DEFINES_SVH

`ifndef ASSERT_OFF

`define BSOC_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define BSOC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define BSOC_ASSERT_IMPL(lbl, ante, cons, msg)

`define BSOC_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ===== rtl/bsoc_sop_pkg.sv =====
// shared types, codes and constants of the battery soc/sop estimator
// no dependencies
`timescale 1ns / 1ps

package bsoc_sop_pkg;

    // sample kinds
    localparam logic [1:0] CMD_VOLT    = 2'd0;
    localparam logic [1:0] CMD_TEMP    = 2'd1;
    localparam logic [1:0] CMD_CURRENT = 2'd2;

    // configuration register indexes
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 18;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOCK    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOPE   = 3'd4;

    // register reset values
    localparam logic [8:0]         ALPHA_RST   = 9'd51;
    localparam logic [17:0]        GAIN_RST    = 18'd29826;
    localparam logic signed [15:0] LOCK_RST    = 16'sd600;
    localparam logic signed [15:0] RELEASE_RST = 16'sd500;
    localparam logic [9:0]         SLOPE_RST   = 10'd10;

    localparam logic [8:0]         ALPHA_ONE   = 9'd256;
    localparam logic [39:0]        FULL_CHARGE = 40'h64_0000_0000;
    localparam logic signed [15:0] VMIN_START  = 16'sd5000;
    localparam logic [9:0]         SOP_FULL    = 10'd1000;
    localparam logic [13:0]        SOC_MAX     = 14'd10000;

    typedef struct packed {
        logic [1:0]         cmd;
        logic signed [15:0] sample;
    } in_item_t;

    typedef struct packed {
        logic [13:0]        soc_hundredths;
        logic [9:0]         sop_tenths;
        logic signed [15:0] current_filtered;
        logic [14:0]        temp_max;
        logic [14:0]        volt_max;
        logic signed [15:0] volt_min;
        logic               locked;
    } out_item_t;

    // controller to datapath
    typedef struct packed {
        logic upd_volt;
        logic upd_temp;
        logic load_sample;
        logic avg_mul;
        logic avg_upd;
        logic dec_mul;
        logic chg_upd;
        logic out_load;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_volt;
        logic is_temp;
        logic is_current;
    } dp_stat_t;

endpackage

// ===== rtl/bsoc_sop_ctrl.sv =====
// sequencer of the battery soc/sop estimator
// depends on bsoc_sop_pkg
`timescale 1ns / 1ps

module bsoc_sop_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    output logic                   out_valid,
    input  logic                   out_ready,
    input  bsoc_sop_pkg::dp_stat_t stat,
    output bsoc_sop_pkg::dp_cmd_t  cmd
);
    import bsoc_sop_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_AVG1 = 3'd1;
    localparam logic [2:0] ST_AVG2 = 3'd2;
    localparam logic [2:0] ST_DEC  = 3'd3;
    localparam logic [2:0] ST_CHG  = 3'd4;
    localparam logic [2:0] ST_OUT  = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       accept;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign accept    = in_valid && in_ready;

    always_comb
    begin
        cmd             = '0;
        state_next      = state_reg;
        cmd.upd_volt    = accept && stat.is_volt;
        cmd.upd_temp    = accept && stat.is_temp;
        cmd.load_sample = accept && stat.is_current;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && stat.is_current)
                begin
                    state_next = ST_AVG1;
                end
            end
            ST_AVG1:
            begin
                cmd.avg_mul = 1'b1;
                state_next  = ST_AVG2;
            end
            ST_AVG2:
            begin
                cmd.avg_upd = 1'b1;
                state_next  = ST_DEC;
            end
            ST_DEC:
            begin
                cmd.dec_mul = 1'b1;
                state_next  = ST_CHG;
            end
            ST_CHG:
            begin
                cmd.chg_upd = 1'b1;
                state_next  = ST_OUT;
            end
            ST_OUT:
            begin
                // hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== rtl/bsoc_sop_dp.sv =====
// datapath of the battery soc/sop estimator: config registers, extremes,
// moving average, charge counter, thermal derating, output register
// depends on bsoc_sop_pkg
`timescale 1ns / 1ps

module bsoc_sop_dp (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [bsoc_sop_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [bsoc_sop_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  bsoc_sop_pkg::in_item_t                in_data,
    output bsoc_sop_pkg::out_item_t               out_data,
    input  bsoc_sop_pkg::dp_cmd_t                 cmd,
    output bsoc_sop_pkg::dp_stat_t                stat
);
    import bsoc_sop_pkg::*;

    // configuration
    logic [8:0]         alpha_reg;
    logic [17:0]        gain_reg;
    logic signed [15:0] lock_reg;
    logic signed [15:0] release_reg;
    logic [9:0]         slope_reg;

    // state
    logic signed [15:0] sample_reg;
    logic signed [23:0] avg_reg;
    logic signed [23:0] avg_next;
    logic               first_reg;
    logic [39:0]        charge_reg;
    logic [39:0]        charge_next;
    logic               latch_reg;
    logic               latch_next;
    logic signed [15:0] tmax_reg;
    logic signed [15:0] vmax_reg;
    logic signed [15:0] vmin_reg;
    logic signed [33:0] prod_reg;
    logic signed [42:0] dec_reg;
    logic [9:0]         sop_reg;
    logic [9:0]         sop_next;
    out_item_t          out_reg;
    out_item_t          out_next;

    // arithmetic
    logic [8:0]         alpha_cl;
    logic [8:0]         alpha_inv;
    logic signed [9:0]  alpha_s;
    logic signed [9:0]  alpha_inv_s;
    logic signed [33:0] prod_avg;
    logic signed [25:0] new_term;
    logic signed [34:0] acc_sum;
    logic signed [18:0] gain_s;
    logic signed [42:0] dec_prod;
    logic signed [41:0] charge_diff;
    logic signed [16:0] temp_diff;
    logic signed [27:0] derate;
    logic [46:0]        soc_prod;
    logic [15:0]        cur_int;

    assign stat.is_volt    = (in_data.cmd == CMD_VOLT);
    assign stat.is_temp    = (in_data.cmd == CMD_TEMP);
    assign stat.is_current = (in_data.cmd == CMD_CURRENT);

    // moving average
    assign alpha_cl    = (alpha_reg > ALPHA_ONE) ? ALPHA_ONE : alpha_reg;
    assign alpha_inv   = ALPHA_ONE - alpha_cl;
    assign alpha_s     = signed'({1'b0, alpha_cl});
    assign alpha_inv_s = signed'({1'b0, alpha_inv});
    assign prod_avg    = alpha_inv_s * avg_reg;
    assign new_term    = alpha_s * sample_reg;
    assign acc_sum     = signed'({new_term[25], new_term, 8'd0})
                       + signed'({prod_reg[33], prod_reg});

    always_comb
    begin
        if (first_reg)
        begin
            avg_next = signed'({sample_reg, 8'd0});
        end
        else
        begin
            // floor of the sum over 256
            avg_next = acc_sum[31:8];
        end
    end

    // charge counter
    assign gain_s      = signed'({1'b0, gain_reg});
    assign dec_prod    = avg_reg * gain_s;
    assign charge_diff = signed'({2'b00, charge_reg})
                       - signed'({{7{dec_reg[42]}}, dec_reg[42:8]});

    always_comb
    begin
        if (charge_diff[41])
        begin
            charge_next = '0;
        end
        else if (charge_diff > signed'({2'b00, FULL_CHARGE}))
        begin
            charge_next = FULL_CHARGE;
        end
        else
        begin
            charge_next = charge_diff[39:0];
        end
    end

    // thermal latch and derating
    assign temp_diff = signed'({tmax_reg[15], tmax_reg})
                     - signed'({release_reg[15], release_reg});
    assign derate    = temp_diff * signed'({1'b0, slope_reg});

    always_comb
    begin
        latch_next = latch_reg;
        if (tmax_reg >= lock_reg)
        begin
            latch_next = 1'b1;
        end
        else if (latch_reg && (tmax_reg <= release_reg))
        begin
            latch_next = 1'b0;
        end

        if (latch_next)
        begin
            sop_next = '0;
        end
        else if (tmax_reg < release_reg)
        begin
            sop_next = SOP_FULL;
        end
        else if (derate > 28'sd1000)
        begin
            sop_next = '0;
        end
        else
        begin
            sop_next = SOP_FULL - derate[9:0];
        end
    end

    // charge times 100 by shift and add, integer part in bits 45:32
    assign soc_prod = ({7'd0, charge_reg} << 6) + ({7'd0, charge_reg} << 5)
                    + ({7'd0, charge_reg} << 2);
    // truncate toward zero
    assign cur_int  = avg_reg[23:8] + {15'd0, (avg_reg[23] && (|avg_reg[7:0]))};

    always_comb
    begin
        out_next                  = out_reg;
        out_next.soc_hundredths   = soc_prod[45:32];
        out_next.sop_tenths       = sop_reg;
        out_next.current_filtered = cur_int;
        out_next.temp_max         = tmax_reg[14:0];
        out_next.volt_max         = vmax_reg[14:0];
        out_next.volt_min         = vmin_reg;
        out_next.locked           = latch_reg;
    end

    assign out_data = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_reg   <= ALPHA_RST;
            gain_reg    <= GAIN_RST;
            lock_reg    <= LOCK_RST;
            release_reg <= RELEASE_RST;
            slope_reg   <= SLOPE_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_ALPHA:   alpha_reg   <= cfg_data[8:0];
                CFG_GAIN:    gain_reg    <= cfg_data[17:0];
                CFG_LOCK:    lock_reg    <= signed'(cfg_data[15:0]);
                CFG_RELEASE: release_reg <= signed'(cfg_data[15:0]);
                CFG_SLOPE:   slope_reg   <= cfg_data[9:0];
                default:     ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            avg_reg    <= '0;
            first_reg  <= 1'b1;
            charge_reg <= FULL_CHARGE;
            latch_reg  <= 1'b0;
            tmax_reg   <= '0;
            vmax_reg   <= '0;
            vmin_reg   <= VMIN_START;
        end
        else
        begin
            if (cmd.avg_upd)
            begin
                avg_reg   <= avg_next;
                first_reg <= 1'b0;
            end
            if (cmd.chg_upd)
            begin
                charge_reg <= charge_next;
            end
            if (cmd.avg_mul)
            begin
                latch_reg <= latch_next;
            end
            if (cmd.out_load)
            begin
                tmax_reg <= '0;
                vmax_reg <= '0;
                vmin_reg <= VMIN_START;
            end
            else
            begin
                if (cmd.upd_volt && (in_data.sample > vmax_reg))
                begin
                    vmax_reg <= in_data.sample;
                end
                if (cmd.upd_volt && (in_data.sample < vmin_reg))
                begin
                    vmin_reg <= in_data.sample;
                end
                if (cmd.upd_temp && (in_data.sample > tmax_reg))
                begin
                    tmax_reg <= in_data.sample;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_sample)
        begin
            sample_reg <= in_data.sample;
        end
        if (cmd.avg_mul)
        begin
            prod_reg <= prod_avg;
            sop_reg  <= sop_next;
        end
        if (cmd.dec_mul)
        begin
            dec_reg <= dec_prod;
        end
        if (cmd.out_load)
        begin
            out_reg <= out_next;
        end
    end

endmodule

// ===== rtl/battery_soc_sop_estimator_core.sv =====
// top level of the battery soc/sop estimator: sequencer plus datapath
// depends on bsoc_sop_pkg, bsoc_sop_ctrl, bsoc_sop_dp and the defines header
//
//   channel  | signals                           | moves
//   ---------+-----------------------------------+---------------------------
//   in       | in_valid, in_ready, in_data       | one sensor sample request
//   out      | out_valid, out_ready, out_data    | one telemetry request
//   cfg      | cfg_we, cfg_index, cfg_data       | register write, no wait
//
// voltage and temperature samples leave the sequencer in idle and never stall on the output
// a current sample steps through avg product, avg update, charge product, charge update
// and output load; in_ready stays low until the output load, when in_ready and out_valid
// rise together; the output load waits while an earlier result is not yet taken
// reset restores config, average, charge, latch, extremes and handshake, no clearing pass
`timescale 1ns / 1ps
`include "battery_soc_sop_estimator_core_defines.svh"

module battery_soc_sop_estimator_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  bsoc_sop_pkg::in_item_t              in_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output bsoc_sop_pkg::out_item_t             out_data,
    input  logic                                cfg_we,
    input  logic [bsoc_sop_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bsoc_sop_pkg::CFG_DATA_W-1:0] cfg_data
);
    import bsoc_sop_pkg::*;

    dp_cmd_t  dp_cmd;
    dp_stat_t dp_stat;

    bsoc_sop_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (dp_stat),
        .cmd       (dp_cmd)
    );

    bsoc_sop_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (in_data),
        .out_data  (out_data),
        .cmd       (dp_cmd),
        .stat      (dp_stat)
    );

    `BSOC_ASSERT_IMPL(a_soc_range, out_valid, out_data.soc_hundredths <= SOC_MAX, "soc out of range")
    `BSOC_ASSERT_IMPL(a_sop_range, out_valid, out_data.sop_tenths <= SOP_FULL, "sop out of range")
    `BSOC_ASSERT_IMPL(a_lock_zero, out_valid && out_data.locked, out_data.sop_tenths == '0, "locked with power")
    `BSOC_ASSERT_NEXT(a_busy, in_valid && in_ready && (in_data.cmd == CMD_CURRENT), !in_ready, "ready while busy")

endmodule
